// ===== sv/atte_pkg.sv =====
// shared types, constants and command codes of the text terminal engine
// no dependencies; every module of the block imports this package
`timescale 1ns / 1ps
`default_nettype none

package atte_pkg;

  localparam int LINES_IN_STORE = 128;
  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int MAX_PARAMS     = 8;
  localparam int TAB_WIDTH      = 4;

  localparam int LINE_W  = $clog2(LINES_IN_STORE);
  localparam int USE_W   = $clog2(LINES_IN_STORE + 1);
  localparam int REL_W   = USE_W + 1;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int PARAM_W = 14;
  localparam int CELLS   = LINES_IN_STORE * SCREEN_COLUMNS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int PCNT_W  = $clog2(MAX_PARAMS + 1);
  localparam int PIDX_W  = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int TAB_W   = $clog2(TAB_WIDTH + 1);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [PARAM_W-1:0] PARAM_MAX     = 14'd16383;
  localparam logic [7:0]         DEFAULT_COLOR = 8'h07;
  localparam logic [7:0]         SPACE_CHAR    = 8'h20;
  localparam logic [7:0]         ESC_CHAR      = 8'h1B;
  localparam logic [7:0]         LF_CHAR       = 8'h0A;
  localparam logic [7:0]         CR_CHAR       = 8'h0D;
  localparam logic [7:0]         TAB_CHAR      = 8'h09;
  localparam logic [7:0]         BS_CHAR       = 8'h08;

  localparam logic [2:0] OP_BYTE   = 3'd0;
  localparam logic [2:0] OP_READ   = 3'd1;
  localparam logic [2:0] OP_COLOR  = 3'd2;
  localparam logic [2:0] OP_CURSOR = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  typedef enum logic [3:0] {
    CMD_TEXT,
    CMD_READ,
    CMD_COLOR,
    CMD_CURSOR,
    CMD_CLEAR,
    CMD_SGR,
    CMD_POS,
    CMD_ED,
    CMD_EL,
    CMD_CUU,
    CMD_CUD,
    CMD_CUF,
    CMD_CUB
  } cmd_e;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] value;
    logic [4:0] row;
    logic [6:0] col;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [13:0] param_value;
    logic        last;
    logic [7:0]  cell_char;
    logic [7:0]  cell_color;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
  } out_item_t;

  typedef struct packed {
    cmd_e               cmd;
    logic [7:0]         value;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [PARAM_W-1:0] p0;
    logic [PARAM_W-1:0] p1;
    logic               last;
  } cmd_t;

endpackage

`default_nettype wire

// ===== sv/atte_front.sv =====
// front end: accepts input items, runs the escape sequence parser and
// turns each item into commands for the back end; uses atte_pkg
`timescale 1ns / 1ps
`default_nettype none

module atte_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  atte_pkg::in_item_t  in_data_i,
  output logic                push_valid_o,
  input  wire                 push_ready_i,
  output atte_pkg::cmd_t      push_data_o
);
  import atte_pkg::*;

  localparam logic FR_IDLE = 1'b0;
  localparam logic FR_EMIT = 1'b1;

  localparam logic [1:0] PH_TEXT = 2'd0;
  localparam logic [1:0] PH_ESC  = 2'd1;
  localparam logic [1:0] PH_CSI  = 2'd2;

  logic               st_q, st_d;
  logic [1:0]         phase_q, phase_d;
  logic [PARAM_W-1:0] plist_q [MAX_PARAMS];
  logic [PCNT_W-1:0]  pcnt_q, pcnt_d;
  logic [PARAM_W-1:0] accum_q, accum_d;
  logic               seen_q, seen_d;
  logic [PCNT_W-1:0]  emit_q, emit_d;
  cmd_e               final_q, final_d;

  logic               plist_we;
  logic [PARAM_W-1:0] plist_wd;
  logic               accept;
  logic [7:0]         b;
  logic [17:0]        acc_ext;
  logic               fin_ok;
  cmd_e               fin_cmd;

  assign in_ready_o = (st_q == FR_IDLE) && push_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign b          = in_data_i.value;
  assign acc_ext    = 18'(accum_q) * 18'd10 + 18'(b - "0");

  // final byte classification
  always_comb begin
    fin_ok  = 1'b1;
    fin_cmd = CMD_SGR;
    case (b)
      "m":      fin_cmd = CMD_SGR;
      "H", "f": fin_cmd = CMD_POS;
      "J":      fin_cmd = CMD_ED;
      "K":      fin_cmd = CMD_EL;
      "A":      fin_cmd = CMD_CUU;
      "B":      fin_cmd = CMD_CUD;
      "C":      fin_cmd = CMD_CUF;
      "D":      fin_cmd = CMD_CUB;
      default:  fin_ok  = 1'b0;
    endcase
  end

  always_comb begin
    st_d     = st_q;
    phase_d  = phase_q;
    pcnt_d   = pcnt_q;
    accum_d  = accum_q;
    seen_d   = seen_q;
    emit_d   = emit_q;
    final_d  = final_q;
    plist_we = 1'b0;
    plist_wd = seen_q ? accum_q : '0;

    push_valid_o       = 1'b0;
    push_data_o.cmd    = CMD_TEXT;
    push_data_o.value  = in_data_i.value;
    push_data_o.row    = in_data_i.row;
    push_data_o.col    = in_data_i.col;
    push_data_o.p0     = '0;
    push_data_o.p1     = '0;
    push_data_o.last   = 1'b0;

    if (st_q == FR_IDLE) begin
      if (accept) begin
        case (in_data_i.op)
          OP_BYTE: begin
            if (phase_q == PH_ESC && b == "[") begin
              phase_d = PH_CSI;
              pcnt_d  = '0;
              accum_d = '0;
              seen_d  = 1'b0;
            end else if (phase_q == PH_CSI) begin
              if (b inside {["0":"9"]}) begin
                accum_d = (acc_ext > 18'(PARAM_MAX)) ? PARAM_MAX : acc_ext[PARAM_W-1:0];
                seen_d  = 1'b1;
              end else begin
                if (pcnt_q < PCNT_W'(MAX_PARAMS)) begin
                  plist_we = 1'b1;
                  pcnt_d   = pcnt_q + 1'b1;
                end
                accum_d = '0;
                seen_d  = 1'b0;
                if (b != ";") begin
                  phase_d = PH_TEXT;
                  if (fin_ok) begin
                    st_d    = FR_EMIT;
                    final_d = fin_cmd;
                    emit_d  = '0;
                  end
                end
              end
            end else begin
              phase_d = PH_TEXT;
              if (b == ESC_CHAR) begin
                phase_d = PH_ESC;
              end else begin
                push_valid_o = 1'b1;
              end
            end
          end
          OP_READ: begin
            push_valid_o    = 1'b1;
            push_data_o.cmd = CMD_READ;
          end
          OP_COLOR: begin
            push_valid_o    = 1'b1;
            push_data_o.cmd = CMD_COLOR;
          end
          OP_CURSOR: begin
            push_valid_o    = 1'b1;
            push_data_o.cmd = CMD_CURSOR;
          end
          OP_CLEAR: begin
            push_valid_o    = 1'b1;
            push_data_o.cmd = CMD_CLEAR;
          end
          default: ;
        endcase
      end
    end else begin
      push_valid_o    = 1'b1;
      push_data_o.cmd = final_q;
      if (final_q == CMD_SGR) begin
        push_data_o.p0   = plist_q[emit_q[PIDX_W-1:0]];
        push_data_o.last = (emit_q + 1'b1) == pcnt_q;
        if (push_ready_i) begin
          emit_d = emit_q + 1'b1;
          if (push_data_o.last) begin
            st_d = FR_IDLE;
          end
        end
      end else begin
        push_data_o.p0 = plist_q[0];
        push_data_o.p1 = (pcnt_q >= PCNT_W'(2)) ? plist_q[1 % MAX_PARAMS] : PARAM_W'(1);
        if (push_ready_i) begin
          st_d = FR_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= FR_IDLE;
      phase_q <= PH_TEXT;
      pcnt_q  <= '0;
      accum_q <= '0;
      seen_q  <= 1'b0;
      emit_q  <= '0;
      final_q <= CMD_SGR;
    end else begin
      st_q    <= st_d;
      phase_q <= phase_d;
      pcnt_q  <= pcnt_d;
      accum_q <= accum_d;
      seen_q  <= seen_d;
      emit_q  <= emit_d;
      final_q <= final_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (plist_we) begin
      plist_q[pcnt_q[PIDX_W-1:0]] <= plist_wd;
    end
  end

endmodule

`default_nettype wire

// ===== sv/atte_fifo.sv =====
// short command queue between the front and back ends
// uses atte_pkg for the entry type and depth
`timescale 1ns / 1ps
`default_nettype none

module atte_fifo (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             push_valid_i,
  output logic            push_ready_o,
  input  atte_pkg::cmd_t  push_data_i,
  output logic            pop_valid_o,
  input  wire             pop_ready_i,
  output atte_pkg::cmd_t  pop_data_o
);
  import atte_pkg::*;

  cmd_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic                  do_push, do_pop;

  assign push_ready_o = cnt_q != FIFO_CNT_W'(FIFO_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/atte_back.sv =====
// back end: sequencer over the line ring, cell memories and cursor,
// with the result register; uses atte_pkg
`timescale 1ns / 1ps
`default_nettype none

module atte_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cmd_valid_i,
  output logic                cmd_ready_o,
  input  atte_pkg::cmd_t      cmd_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output atte_pkg::out_item_t out_data_o
);
  import atte_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_GROW  = 4'd1;
  localparam logic [3:0] S_LOOK  = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_FILL  = 4'd4;
  localparam logic [3:0] S_ADV   = 4'd5;
  localparam logic [3:0] S_NL    = 4'd6;
  localparam logic [3:0] S_NLEND = 4'd7;
  localparam logic [3:0] S_READ  = 4'd8;
  localparam logic [3:0] S_ERASE = 4'd9;

  logic [3:0]                state_q, state_d;
  logic [LINE_W-1:0]         head_q, head_d;
  logic [USE_W-1:0]          lines_q, lines_d;
  logic [COL_W-1:0]          cx_q, cx_d;
  logic [ROW_W-1:0]          cy_q, cy_d;
  logic [7:0]                color_q, color_d;
  logic [LINES_IN_STORE-1:0] valid_q, valid_d;
  logic [LINE_W-1:0]         line_q, line_d;
  logic [COL_W-1:0]          scan_q, scan_d;
  logic [COL_W-1:0]          fill_q, fill_d;
  logic                      fset_q, fset_d;
  logic [3:0]                fret_q, fret_d;
  logic [TAB_W-1:0]          tab_q, tab_d;
  logic [7:0]                char_q, char_d;
  logic                      wr_q, wr_d;
  logic [ROW_W-1:0]          ey_q, ey_d;
  logic                      home_q, home_d;
  logic                      ruse_q, ruse_d;
  logic                      out_valid_q;
  out_item_t                 out_q, out_d;
  logic                      ld_out;

  // cell memories
  logic [7:0]        char_mem  [CELLS];
  logic [7:0]        color_mem [CELLS];
  logic [7:0]        char_rd_q, color_rd_q;
  logic              char_we, color_we, rd_en;
  logic [LINE_W-1:0] mem_line;
  logic [COL_W-1:0]  mem_x;
  logic [7:0]        wch, wcol;
  logic [ADDR_W-1:0] mem_addr;

  logic [ROW_W-1:0]   map_y;
  logic [USE_W-1:0]   top_w;
  logic [REL_W-1:0]   rel_w, nl_rel;
  logic               stored_w;
  logic [LINE_W-1:0]  map_line, nl_line, app_line, head_inc;
  logic               out_free;
  logic               do_next_row, do_append;
  logic [PARAM_W-1:0] n_w;
  logic [PARAM_W:0]   sum_w;
  logic [COL_W-1:0]   from_w;

  function automatic logic [LINE_W-1:0] wrap_line(input logic [LINE_W-1:0] h,
                                                 input logic [REL_W-1:0] r);
    logic [REL_W:0] s;
    s = (REL_W+1)'(h) + (REL_W+1)'(r);
    if (s >= (REL_W+1)'(LINES_IN_STORE)) begin
      s = s - (REL_W+1)'(LINES_IN_STORE);
    end
    return s[LINE_W-1:0];
  endfunction

  // 1-based position, zero taken as one, clamped to the limit
  function automatic logic [COL_W-1:0] clamp_pos(input logic [PARAM_W-1:0] v,
                                                input logic [PARAM_W-1:0] lim);
    logic [PARAM_W-1:0] t;
    t = v;
    if (t < PARAM_W'(1)) begin
      t = PARAM_W'(1);
    end
    if (t > lim) begin
      t = lim;
    end
    return COL_W'(t - PARAM_W'(1));
  endfunction

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    map_y = cy_q;
    if (state_q == S_ERASE) begin
      map_y = ey_q;
    end else if (state_q == S_IDLE && cmd_i.cmd == CMD_READ) begin
      map_y = cmd_i.row;
    end
  end

  assign top_w    = (lines_q > USE_W'(SCREEN_ROWS)) ? lines_q - USE_W'(SCREEN_ROWS) : '0;
  assign rel_w    = REL_W'(top_w) + REL_W'(map_y);
  assign stored_w = rel_w < REL_W'(lines_q);
  assign map_line = wrap_line(head_q, rel_w);
  assign nl_rel   = stored_w ? rel_w : REL_W'(lines_q) - 1'b1;
  assign nl_line  = wrap_line(head_q, nl_rel);
  assign app_line = (lines_q < USE_W'(LINES_IN_STORE)) ?
                    wrap_line(head_q, REL_W'(lines_q)) : head_q;
  assign head_inc = (head_q == LINE_W'(LINES_IN_STORE - 1)) ? '0 : head_q + 1'b1;
  assign n_w      = (cmd_i.p0 == '0) ? PARAM_W'(1) : cmd_i.p0;
  assign from_w   = (cmd_i.p0 == '0) ? cx_q : '0;
  assign mem_addr = ADDR_W'(mem_line) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(mem_x);

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    lines_d  = lines_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    color_d  = color_q;
    valid_d  = valid_q;
    line_d   = line_q;
    scan_d   = scan_q;
    fill_d   = fill_q;
    fset_d   = fset_q;
    fret_d   = fret_q;
    tab_d    = tab_q;
    char_d   = char_q;
    wr_d     = wr_q;
    ey_d     = ey_q;
    home_d   = home_q;
    ruse_d   = ruse_q;
    sum_w    = '0;

    cmd_ready_o = 1'b0;
    do_next_row = 1'b0;
    do_append   = 1'b0;
    ld_out      = 1'b0;
    out_d       = out_q;

    char_we  = 1'b0;
    color_we = 1'b0;
    rd_en    = 1'b0;
    mem_line = map_line;
    mem_x    = cx_q;
    wch      = '0;
    wcol     = DEFAULT_COLOR;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_ready_o = 1'b1;
          case (cmd_i.cmd)
            CMD_TEXT: begin
              if (cmd_i.value == CR_CHAR) begin
                cx_d = '0;
              end else if (cmd_i.value == BS_CHAR) begin
                if (cx_q != '0) begin
                  cx_d  = cx_q - 1'b1;
                  mem_x = cx_q - 1'b1;
                  // an invalid line already reads as empty
                  if (stored_w && valid_q[map_line]) begin
                    char_we = 1'b1;
                  end
                end
              end else begin
                if (lines_q == '0) begin
                  lines_d = USE_W'(1);
                  head_d  = '0;
                end
                if (cmd_i.value == LF_CHAR) begin
                  state_d = S_NL;
                end else begin
                  char_d  = (cmd_i.value == TAB_CHAR) ? SPACE_CHAR : cmd_i.value;
                  tab_d   = (cmd_i.value == TAB_CHAR) ?
                            TAB_W'(TAB_WIDTH - int'(cx_q % TAB_WIDTH)) : TAB_W'(1);
                  state_d = S_GROW;
                end
              end
            end
            CMD_READ: begin
              ruse_d = 1'b0;
              if (cmd_i.row < ROW_W'(SCREEN_ROWS) && cmd_i.col < COL_W'(SCREEN_COLUMNS) &&
                  stored_w && valid_q[map_line]) begin
                ruse_d = 1'b1;
                rd_en  = 1'b1;
                mem_x  = cmd_i.col;
              end
              state_d = S_READ;
            end
            CMD_COLOR: begin
              color_d = cmd_i.value;
            end
            CMD_CURSOR: begin
              cy_d = (cmd_i.row < ROW_W'(SCREEN_ROWS)) ? cmd_i.row : ROW_W'(SCREEN_ROWS - 1);
              cx_d = (cmd_i.col < COL_W'(SCREEN_COLUMNS)) ? cmd_i.col :
                     COL_W'(SCREEN_COLUMNS - 1);
            end
            CMD_CLEAR: begin
              valid_d = '0;
              head_d  = '0;
              lines_d = '0;
              cx_d    = '0;
              cy_d    = '0;
            end
            CMD_SGR: begin
              cmd_ready_o = out_free;
              if (out_free) begin
                ld_out            = 1'b1;
                out_d.kind        = 1'b1;
                out_d.param_value = cmd_i.p0;
                out_d.last        = cmd_i.last;
                out_d.cell_char   = '0;
                out_d.cell_color  = '0;
                out_d.cursor_row  = cy_q;
                out_d.cursor_col  = cx_q;
              end
            end
            CMD_POS: begin
              cy_d = ROW_W'(clamp_pos(cmd_i.p0, PARAM_W'(SCREEN_ROWS)));
              cx_d = clamp_pos(cmd_i.p1, PARAM_W'(SCREEN_COLUMNS));
            end
            CMD_ED: begin
              if (cmd_i.p0 == '0) begin
                ey_d    = cy_q;
                home_d  = 1'b0;
                state_d = S_ERASE;
              end else if (cmd_i.p0 == PARAM_W'(2)) begin
                ey_d    = '0;
                home_d  = 1'b1;
                state_d = S_ERASE;
              end
            end
            CMD_EL: begin
              if ((cmd_i.p0 == '0 || cmd_i.p0 == PARAM_W'(2)) && stored_w) begin
                if (from_w == '0) begin
                  valid_d[map_line] = 1'b0;
                end else if (valid_q[map_line]) begin
                  line_d  = map_line;
                  fill_d  = from_w;
                  fset_d  = 1'b0;
                  fret_d  = S_IDLE;
                  state_d = S_FILL;
                end
              end
            end
            CMD_CUU: begin
              cy_d = (n_w > PARAM_W'(cy_q)) ? '0 : ROW_W'(PARAM_W'(cy_q) - n_w);
            end
            CMD_CUD: begin
              sum_w = (PARAM_W+1)'(cy_q) + (PARAM_W+1)'(n_w);
              cy_d  = (sum_w >= (PARAM_W+1)'(SCREEN_ROWS)) ? ROW_W'(SCREEN_ROWS - 1) :
                      ROW_W'(sum_w);
            end
            CMD_CUF: begin
              sum_w = (PARAM_W+1)'(cx_q) + (PARAM_W+1)'(n_w);
              cx_d  = (sum_w >= (PARAM_W+1)'(SCREEN_COLUMNS)) ?
                      COL_W'(SCREEN_COLUMNS - 1) : COL_W'(sum_w);
            end
            CMD_CUB: begin
              cx_d = (n_w > PARAM_W'(cx_q)) ? '0 : COL_W'(PARAM_W'(cx_q) - n_w);
            end
            default: ;
          endcase
        end
      end
      // add lines until the cursor row is stored
      S_GROW: begin
        if (!stored_w && lines_q < USE_W'(LINES_IN_STORE)) begin
          do_append = 1'b1;
        end else begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        if (stored_w) begin
          line_d = map_line;
          wr_d   = 1'b1;
          if (!valid_q[map_line]) begin
            cx_d    = '0;
            fill_d  = '0;
            fset_d  = 1'b1;
            fret_d  = S_ADV;
            state_d = S_FILL;
          end else begin
            scan_d  = '0;
            rd_en   = 1'b1;
            mem_x   = '0;
            state_d = S_SCAN;
          end
        end else begin
          wr_d    = 1'b0;
          state_d = S_ADV;
        end
      end
      // text length scan, one cell per cycle
      S_SCAN: begin
        mem_line = line_q;
        if (char_rd_q == '0) begin
          if (cx_q > scan_q) begin
            cx_d = scan_q;
          end
          state_d = S_ADV;
        end else if (scan_q == COL_W'(SCREEN_COLUMNS - 1)) begin
          state_d = S_ADV;
        end else begin
          scan_d = scan_q + 1'b1;
          rd_en  = 1'b1;
          mem_x  = scan_q + 1'b1;
        end
      end
      S_FILL: begin
        mem_line = line_q;
        mem_x    = fill_q;
        char_we  = 1'b1;
        color_we = 1'b1;
        if (fill_q == COL_W'(SCREEN_COLUMNS - 1)) begin
          if (fset_q) begin
            valid_d[line_q] = 1'b1;
          end
          state_d = fret_q;
        end else begin
          fill_d = fill_q + 1'b1;
        end
      end
      S_ADV: begin
        mem_line = line_q;
        mem_x    = cx_q;
        wch      = char_q;
        wcol     = color_q;
        char_we  = wr_q;
        color_we = wr_q;
        if (cx_q == COL_W'(SCREEN_COLUMNS - 1)) begin
          cx_d        = '0;
          do_next_row = 1'b1;
        end else begin
          cx_d = cx_q + 1'b1;
        end
        if (tab_q > TAB_W'(1)) begin
          tab_d   = tab_q - 1'b1;
          state_d = S_GROW;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_NL: begin
        if (cx_q == '0 || !valid_q[nl_line]) begin
          if (cx_q == '0) begin
            valid_d[nl_line] = 1'b0;
          end
          cx_d        = '0;
          do_next_row = 1'b1;
          state_d     = S_IDLE;
        end else begin
          line_d  = nl_line;
          fill_d  = cx_q;
          fset_d  = 1'b0;
          fret_d  = S_NLEND;
          state_d = S_FILL;
        end
      end
      S_NLEND: begin
        cx_d        = '0;
        do_next_row = 1'b1;
        state_d     = S_IDLE;
      end
      S_READ: begin
        if (out_free) begin
          ld_out            = 1'b1;
          out_d.kind        = 1'b0;
          out_d.param_value = '0;
          out_d.last        = 1'b0;
          out_d.cell_char   = (ruse_q && char_rd_q != '0) ? char_rd_q : SPACE_CHAR;
          out_d.cell_color  = ruse_q ? color_rd_q : DEFAULT_COLOR;
          out_d.cursor_row  = cy_q;
          out_d.cursor_col  = cx_q;
          state_d           = S_IDLE;
        end
      end
      // whole-row erase, one row per cycle
      S_ERASE: begin
        if (stored_w) begin
          valid_d[map_line] = 1'b0;
        end
        if (ey_q == ROW_W'(SCREEN_ROWS - 1)) begin
          if (home_q) begin
            cx_d = '0;
            cy_d = '0;
          end
          state_d = S_IDLE;
        end else begin
          ey_d = ey_q + 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (do_next_row) begin
      if (cy_q < ROW_W'(SCREEN_ROWS - 1)) begin
        cy_d = cy_q + 1'b1;
      end else begin
        do_append = 1'b1;
      end
    end
    if (do_append) begin
      if (lines_q < USE_W'(LINES_IN_STORE)) begin
        lines_d = lines_q + 1'b1;
      end else begin
        head_d = head_inc;
      end
      valid_d[app_line] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      lines_q     <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      color_q     <= DEFAULT_COLOR;
      valid_q     <= '0;
      tab_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      lines_q <= lines_d;
      cx_q    <= cx_d;
      cy_q    <= cy_d;
      color_q <= color_d;
      valid_q <= valid_d;
      tab_q   <= tab_d;
      if (ld_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    line_q <= line_d;
    scan_q <= scan_d;
    fill_q <= fill_d;
    fset_q <= fset_d;
    fret_q <= fret_d;
    char_q <= char_d;
    wr_q   <= wr_d;
    ey_q   <= ey_d;
    home_q <= home_d;
    ruse_q <= ruse_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (char_we) begin
      char_mem[mem_addr] <= wch;
    end
    if (color_we) begin
      color_mem[mem_addr] <= wcol;
    end
    if (rd_en) begin
      char_rd_q  <= char_mem[mem_addr];
      color_rd_q <= color_mem[mem_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/ansi_text_terminal_engine.sv =====
// top level of the text terminal engine: front end, command queue, back end
// depends on atte_pkg, atte_front, atte_fifo and atte_back
//
// usage: items enter on in_valid_i/in_ready_o, one beat per item (op, value,
// row, col); results leave on out_valid_o/out_ready_i, one beat per result.
// the front end parses bytes and queues commands (four deep); the back end
// executes them against a ring of stored lines held in two cell memories.
// a printed byte adds lines until the cursor row is stored, then scans the
// line length one character at a time (up to 80), or initializes a fresh
// line, and writes the cell; a tab repeats that for up to four spaces;
// newline and erase-in-line clear cells to the end of the line;
// erase-in-display clears up to 25 rows, one per screen row; the other ops
// finish in the idle state. a cell read answer passes through the read
// state into the output register. an sgr final byte queues one command per
// parameter, one per cycle while the queue has room.
// reset empties the store at once (per-line valid bits), homes the cursor
// and sets color 7; no clearing pass is needed. when the receiver stalls
// the result waits in the output register, the back end holds, the queue
// fills and then in_ready_o drops.
`timescale 1ns / 1ps
`default_nettype none

module ansi_text_terminal_engine (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  atte_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output atte_pkg::out_item_t out_data_o
);
  import atte_pkg::*;

  logic push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_data, pop_data;

  atte_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  atte_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  atte_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_i       (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== sim/tb_ansi_text_terminal_engine.sv =====
// testbench of the text terminal engine: directed table, then random byte streams
// depends on atte_pkg and ansi_text_terminal_engine; predicts results with its own screen model
`timescale 1ns / 1ps

module tb_ansi_text_terminal_engine;
  import atte_pkg::*;

  localparam int NLINES = LINES_IN_STORE;
  localparam int NCOLS  = SCREEN_COLUMNS;
  localparam int NROWS  = SCREEN_ROWS;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef enum int {PH_TEXT, PH_ESC, PH_CSI} phase_e;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;

  ansi_text_terminal_engine u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // terminal shadow state
  logic [7:0] sh_char [NLINES*NCOLS];
  logic [7:0] sh_color[NLINES*NCOLS];
  int         head, used, cx, cy;
  logic [7:0] cur_color;
  phase_e     phase;
  int         plist[MAX_PARAMS];
  int         pcount, paccum;
  bit         pdigit;

  out_item_t  pending_results[$];
  in_item_t   stim_q[$];
  bit         typed_q[$];
  out_item_t  typed_ans_q[$];
  int         errors = 0;
  bit         no_idle;
  bit         stim_done;

  function automatic void wipe_line(int line, int from);
    for (int x = from; x < NCOLS; x++) begin
      sh_char[line*NCOLS+x]  = 8'h00;
      sh_color[line*NCOLS+x] = DEFAULT_COLOR;
    end
  endfunction

  function automatic int screen_top();
    return used > NROWS ? used - NROWS : 0;
  endfunction

  function automatic bit line_of_row(int y, output int line);
    int rel;
    rel = screen_top() + y;
    line = 0;
    if (rel >= used) return 0;
    line = (head + rel) % NLINES;
    return 1;
  endfunction

  function automatic void open_first();
    if (used == 0) begin
      used = 1;
      head = 0;
      for (int x = 0; x < NCOLS; x++) sh_char[x] = 8'h00;
    end
  endfunction

  function automatic void grow_ring();
    int line;
    if (used < NLINES) begin
      line = (head + used) % NLINES;
      used++;
    end else begin
      head = (head + 1) % NLINES;
      line = (head + used - 1) % NLINES;
    end
    wipe_line(line, 0);
  endfunction

  function automatic void line_feed_row();
    if (cy < NROWS - 1) cy++;
    else grow_ring();
  endfunction

  function automatic void put_glyph(logic [7:0] c);
    int line, len;
    len = 0;
    open_first();
    while (screen_top() + cy >= used && used < NLINES) grow_ring();
    if (line_of_row(cy, line)) begin
      while (len < NCOLS && sh_char[line*NCOLS+len] != 0) len++;
      if (cx > len) cx = len;
      if (cx < NCOLS) begin
        sh_char[line*NCOLS+cx]  = c;
        sh_color[line*NCOLS+cx] = cur_color;
      end
    end
    cx++;
    if (cx >= NCOLS) begin
      cx = 0;
      line_feed_row();
    end
  endfunction

  function automatic void plain_byte(logic [7:0] c);
    int line, rel, n;
    if (c == ESC_CHAR) phase = PH_ESC;
    else if (c == LF_CHAR) begin
      open_first();
      rel = screen_top() + cy;
      if (rel >= used) rel = used - 1;
      wipe_line((head + rel) % NLINES, cx);
      cx = 0;
      line_feed_row();
    end else if (c == CR_CHAR) cx = 0;
    else if (c == TAB_CHAR) begin
      n = TAB_WIDTH - (cx % TAB_WIDTH);
      for (int k = 0; k < n; k++) put_glyph(SPACE_CHAR);
    end else if (c == BS_CHAR) begin
      if (cx > 0) begin
        cx--;
        if (line_of_row(cy, line)) sh_char[line*NCOLS+cx] = 8'h00;
      end
    end else put_glyph(c);
  endfunction

  function automatic void erase_screen_row(int y, int from);
    int line;
    if (line_of_row(y, line)) wipe_line(line, from);
  endfunction

  function automatic int clamp1(int v, int lim);
    if (v < 1) v = 1;
    if (v > lim) v = lim;
    return v - 1;
  endfunction

  function automatic out_item_t make_result(bit kind, int pv, bit lst, int ch, int col);
    out_item_t r;
    r.kind = kind;
    r.param_value = pv[13:0];
    r.last = lst;
    r.cell_char = ch[7:0];
    r.cell_color = col[7:0];
    r.cursor_row = cy[4:0];
    r.cursor_col = cx[6:0];
    return r;
  endfunction

  function automatic void finish_csi(logic [7:0] c);
    int p0, n;
    if (pcount < MAX_PARAMS) begin
      plist[pcount] = pdigit ? paccum : 0;
      pcount = pcount + 1;
    end
    phase = PH_TEXT;
    p0 = pcount >= 1 ? plist[0] : 0;
    n = p0 == 0 ? 1 : p0;
    case (c)
      "m": for (int k = 0; k < pcount; k++)
             pending_results.push_back(make_result(1'b1, plist[k], k + 1 == pcount, 0, 0));
      "H", "f": begin
        cy = clamp1(p0, NROWS);
        cx = clamp1(pcount >= 2 ? plist[1 % MAX_PARAMS] : 1, NCOLS);
      end
      "J": begin
        if (p0 == 0) for (int y = cy; y < NROWS; y++) erase_screen_row(y, 0);
        else if (p0 == 2) begin
          for (int y = 0; y < NROWS; y++) erase_screen_row(y, 0);
          cx = 0;
          cy = 0;
        end
      end
      "K": begin
        if (p0 == 0) erase_screen_row(cy, cx);
        else if (p0 == 2) erase_screen_row(cy, 0);
      end
      "A": cy = n > cy ? 0 : cy - n;
      "B": cy = cy + n >= NROWS ? NROWS - 1 : cy + n;
      "C": cx = cx + n >= NCOLS ? NCOLS - 1 : cx + n;
      "D": cx = n > cx ? 0 : cx - n;
      default: ;
    endcase
  endfunction

  function automatic void feed_byte(logic [7:0] c);
    if (phase == PH_ESC) begin
      if (c == "[") begin
        phase = PH_CSI;
        pcount = 0;
        paccum = 0;
        pdigit = 0;
      end else begin
        phase = PH_TEXT;
        plain_byte(c);
      end
    end else if (phase == PH_CSI) begin
      if (c >= "0" && c <= "9") begin
        paccum = paccum * 10 + int'(c - "0");
        if (paccum > int'(PARAM_MAX)) paccum = int'(PARAM_MAX);
        pdigit = 1;
      end else if (c == ";") begin
        if (pcount < MAX_PARAMS) begin
          plist[pcount] = pdigit ? paccum : 0;
          pcount = pcount + 1;
        end
        paccum = 0;
        pdigit = 0;
      end else finish_csi(c);
    end else plain_byte(c);
  endfunction

  function automatic void empty_store();
    for (int i = 0; i < NLINES*NCOLS; i++) begin
      sh_char[i]  = 8'h00;
      sh_color[i] = DEFAULT_COLOR;
    end
    head = 0;
    used = 0;
    cx = 0;
    cy = 0;
  endfunction

  // computes expected results of one accepted item
  function automatic void predict_item(in_item_t it);
    int line, ch, col;
    case (it.op)
      OP_BYTE: feed_byte(it.value);
      OP_READ: begin
        ch = int'(SPACE_CHAR);
        col = int'(DEFAULT_COLOR);
        if (it.row < NROWS && it.col < NCOLS && line_of_row(int'(it.row), line)) begin
          ch = int'(sh_char[line*NCOLS+int'(it.col)]);
          if (ch == 0) ch = int'(SPACE_CHAR);
          col = int'(sh_color[line*NCOLS+int'(it.col)]);
        end
        pending_results.push_back(make_result(1'b0, 0, 1'b0, ch, col));
      end
      OP_COLOR: cur_color = it.value;
      OP_CURSOR: begin
        cy = it.row < NROWS ? int'(it.row) : NROWS - 1;
        cx = it.col < NCOLS ? int'(it.col) : NCOLS - 1;
      end
      OP_CLEAR: empty_store();
      default: ;
    endcase
  endfunction

  function automatic in_item_t mk(logic [2:0] op, logic [7:0] v, logic [4:0] r, logic [6:0] c);
    in_item_t it;
    it.op = op;
    it.value = v;
    it.row = r;
    it.col = c;
    return it;
  endfunction

  function automatic out_item_t cell_ans(logic [7:0] ch, logic [7:0] col, int r, int c);
    out_item_t a;
    a = '0;
    a.cell_char = ch;
    a.cell_color = col;
    a.cursor_row = r[4:0];
    a.cursor_col = c[6:0];
    return a;
  endfunction

  function automatic void add_row(in_item_t it, bit typed, out_item_t ans);
    stim_q.push_back(it);
    typed_q.push_back(typed);
    typed_ans_q.push_back(ans);
  endfunction

  function automatic void add_byte(logic [7:0] b);
    add_row(mk(OP_BYTE, b, 5'($urandom), 7'($urandom)), 1'b0, '0);
  endfunction

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  // a random escape sequence, mostly well formed
  function automatic void add_csi();
    int np;
    byte finals[12] = '{"m", "H", "f", "J", "K", "A", "B", "C", "D", "m", "q", "m"};
    add_byte(ESC_CHAR);
    if ($urandom_range(0, 15) == 0) begin
      add_byte(8'($urandom));
      return;
    end
    add_byte("[");
    np = $urandom_range(0, 10);
    for (int p = 0; p < np; p++) begin
      case ($urandom_range(0, 4))
        0: ;
        1: add_str($sformatf("%0d", $urandom_range(0, 3)));
        2: add_str($sformatf("%0d", $urandom_range(0, 90)));
        3: add_str($sformatf("%0d", $urandom_range(0, 99999)));
        default: add_byte("2");
      endcase
      if (p != np - 1) add_byte(";");
    end
    if ($urandom_range(0, 20) == 0)
      add_row(mk(OP_READ, 8'd0, 5'($urandom), 7'($urandom)), 1'b0, '0);
    add_byte(finals[$urandom_range(0, 11)]);
  endfunction

  function automatic void build_directed();
    // after reset every cell reads as space, color 7
    add_row(mk(OP_READ, 8'h00, 5'd0, 7'd0), 1, cell_ans(SPACE_CHAR, DEFAULT_COLOR, 0, 0));
    add_row(mk(OP_READ, 8'hFF, 5'd31, 7'd127), 1, cell_ans(SPACE_CHAR, DEFAULT_COLOR, 0, 0));
    add_row(mk(OP_COLOR, 8'hFF, 5'd0, 7'd0), 0, '0);
    add_row(mk(OP_BYTE, "A", 5'd0, 7'd0), 0, '0);
    add_row(mk(OP_READ, 8'h00, 5'd0, 7'd0), 1, cell_ans("A", 8'hFF, 0, 1));
    add_row(mk(OP_CURSOR, 8'h00, 5'd31, 7'd127), 0, '0);
    add_row(mk(OP_BYTE, "B", 5'd0, 7'd0), 0, '0);
    add_row(mk(OP_BYTE, TAB_CHAR, 5'd0, 7'd0), 0, '0);
    add_row(mk(OP_BYTE, BS_CHAR, 5'd0, 7'd0), 0, '0);
    add_row(mk(OP_BYTE, LF_CHAR, 5'd0, 7'd0), 0, '0);
    add_row(mk(OP_BYTE, CR_CHAR, 5'd0, 7'd0), 0, '0);
    add_row(mk(OP_BYTE, ESC_CHAR, 5'd0, 7'd0), 0, '0);
    add_row(mk(OP_BYTE, "x", 5'd0, 7'd0), 0, '0);
    add_str("\033[99999;;5;6;7;8;9;10;11m");
    add_str("\033[5;200H\033[J\033[2K\033[2J\033[A");
    add_row(mk(3'd7, 8'h55, 5'd1, 7'd1), 0, '0);
    add_row(mk(OP_CLEAR, 8'h00, 5'd0, 7'd0), 0, '0);
    add_row(mk(OP_READ, 8'h00, 5'd0, 7'd0), 1, cell_ans(SPACE_CHAR, DEFAULT_COLOR, 0, 0));
  endfunction

  function automatic void build_random(int count);
    int start;
    start = stim_q.size();
    while (stim_q.size() - start < count) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: add_byte(8'($urandom_range(32, 126)));
        5: add_byte(8'($urandom));
        6: add_byte(LF_CHAR);
        7: add_byte(TAB_CHAR);
        8: add_byte(BS_CHAR);
        9: add_byte(CR_CHAR);
        10, 11, 12: add_csi();
        13, 14: add_row(mk(OP_READ, 8'($urandom), 5'($urandom_range(0, 26)),
                           7'($urandom_range(0, 82))), 1'b0, '0);
        15: add_row(mk(OP_COLOR, 8'($urandom), 5'($urandom), 7'($urandom)), 1'b0, '0);
        16: add_row(mk(OP_CURSOR, 8'($urandom), 5'($urandom), 7'($urandom)), 1'b0, '0);
        17: if ($urandom_range(0, 9) == 0)
              add_row(mk(OP_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom)), 1'b0, '0);
        18: add_row(mk(3'($urandom_range(5, 7)), 8'($urandom), 5'($urandom), 7'($urandom)),
                    1'b0, '0);
        default: for (int k = 0; k < 6; k++) add_byte(8'($urandom_range(32, 126)));
      endcase
    end
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // sender
  initial begin
    in_item_t it;
    int gap;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    stim_done = 1'b0;
    no_idle = 1'b0;
    cur_color = DEFAULT_COLOR;
    phase = PH_TEXT;
    pcount = 0;
    paccum = 0;
    pdigit = 0;
    foreach (plist[i]) plist[i] = 0;
    empty_store();
    build_directed();
    build_random(200);
    // long run of newlines to scroll the ring past its size
    for (int k = 0; k < 160; k++) begin
      add_byte(LF_CHAR);
    end
    build_random(60);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    gap = 0;
    while (stim_q.size() > 0) begin
      it = stim_q[0];
      repeat (gap) @(posedge clk_i);
      in_valid_i <= 1'b1;
      in_data_i <= it;
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
      void'(stim_q.pop_front());
      if (typed_q.pop_front()) begin
        pending_results.push_back(typed_ans_q.pop_front());
        // keep the predictor in step without queueing a second copy
        begin
          int before_n;
          before_n = pending_results.size();
          predict_item(it);
          while (pending_results.size() > before_n) void'(pending_results.pop_back());
        end
      end else begin
        void'(typed_ans_q.pop_front());
        predict_item(it);
      end
      if (stim_q.size() == 150) no_idle = 1'b1;
      gap = (!no_idle && $urandom_range(0, 3) == 0) ? int'($urandom_range(1, 8)) : 0;
      if (stim_q.size() == 0 || gap > 0) in_valid_i <= 1'b0;
    end
    stim_done = 1'b1;
  end

  // receiver
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    repeat (300) @(posedge clk_i);
    out_ready_i <= 1'b0;
    // long hold-off so the queue fills and input stalls
    repeat (3000) @(posedge clk_i);
    forever begin
      if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: %h", out_data_o);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (e.kind !== out_data_o.kind) begin
          $error("kind expected %0d actual %0d", e.kind, out_data_o.kind); errors++;
        end
        if (e.param_value !== out_data_o.param_value) begin
          $error("param_value expected %0d actual %0d", e.param_value,
                 out_data_o.param_value); errors++;
        end
        if (e.last !== out_data_o.last) begin
          $error("last expected %0d actual %0d", e.last, out_data_o.last); errors++;
        end
        if (e.cell_char !== out_data_o.cell_char) begin
          $error("cell_char expected %h actual %h", e.cell_char, out_data_o.cell_char);
          errors++;
        end
        if (e.cell_color !== out_data_o.cell_color) begin
          $error("cell_color expected %h actual %h", e.cell_color, out_data_o.cell_color);
          errors++;
        end
        if (e.cursor_row !== out_data_o.cursor_row) begin
          $error("cursor_row expected %0d actual %0d", e.cursor_row, out_data_o.cursor_row);
          errors++;
        end
        if (e.cursor_col !== out_data_o.cursor_col) begin
          $error("cursor_col expected %0d actual %0d", e.cursor_col, out_data_o.cursor_col);
          errors++;
        end
      end
    end
  end

  // watchdog and end of run
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (stim_done && pending_results.size() == 0) begin
        repeat (400) @(posedge clk_i);
        if (errors == 0 && pending_results.size() == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

endmodule
